// ----- rtl/core/urdiv_pkg.sv -----
// ----------------------------------------------------------------------------
// urdiv_pkg: shared types and constants for the unsigned restoring divider
// Operand width, field width, iteration counter sizing, controller command
// struct and the width conversion helpers.
// ----------------------------------------------------------------------------
package urdiv_pkg;

	// Internal division width (operands are zero-extended or truncated to it)
	localparam int WIDTH = 32;
	// Width of each field on the stream ports
	localparam int FIELD_W = 32;
	// Packed word width: two fields, already a whole number of bytes
	localparam int WORD_W = 2 * FIELD_W;

	// Iteration counter
	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	// Common width for field <-> operand conversion
	localparam int EXT_W = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture operands, clear partial remainder
		logic step;    // one shift-subtract iteration
		logic commit;  // write the result of this step into the output register
	} urdiv_cmd_t;

	// Field to operand: zero-extend or truncate
	function automatic logic [WIDTH-1:0] to_op(input logic [FIELD_W-1:0] f);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(f);
		return ext[WIDTH-1:0];
	endfunction

	// Operand to field: zero-extend or truncate
	function automatic logic [FIELD_W-1:0] to_field(input logic [WIDTH-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		return ext[FIELD_W-1:0];
	endfunction

endpackage

// ----- rtl/core/urdiv_dp.sv -----
// ----------------------------------------------------------------------------
// urdiv_dp: divider datapath
// Partial remainder, shifting dividend/quotient register, divisor register,
// one restoring shift-subtract step per command, and the output word register.
// ----------------------------------------------------------------------------
module urdiv_dp (
	input  logic                         clk,
	input  urdiv_pkg::urdiv_cmd_t        cmd,
	input  logic [urdiv_pkg::WORD_W-1:0] in_word,
	output logic [urdiv_pkg::WORD_W-1:0] out_word
);

	logic [urdiv_pkg::WIDTH-1:0] rem_q;
	logic [urdiv_pkg::WIDTH-1:0] quo_q;   // dividend bits shift out, quotient bits shift in
	logic [urdiv_pkg::WIDTH-1:0] div_q;
	logic [urdiv_pkg::WORD_W-1:0] res_q;

	logic [urdiv_pkg::WIDTH:0]   shifted;
	logic [urdiv_pkg::WIDTH+1:0] diff;
	logic                        ge;
	logic [urdiv_pkg::WIDTH-1:0] rem_nxt;
	logic [urdiv_pkg::WIDTH-1:0] quo_nxt;

	// One iteration: shift in next dividend bit, trial subtract, restore on borrow
	always_comb begin
		shifted = {rem_q, quo_q[urdiv_pkg::WIDTH-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		ge      = ~diff[urdiv_pkg::WIDTH+1];
		rem_nxt = ge ? diff[urdiv_pkg::WIDTH-1:0] : shifted[urdiv_pkg::WIDTH-1:0];
		quo_nxt = {quo_q[urdiv_pkg::WIDTH-2:0], ge};
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= urdiv_pkg::to_op(in_word[urdiv_pkg::FIELD_W-1:0]);
			div_q <= urdiv_pkg::to_op(in_word[urdiv_pkg::WORD_W-1:urdiv_pkg::FIELD_W]);
		end else if (cmd.step) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	// Output word: quotient low, remainder high
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= {urdiv_pkg::to_field(rem_nxt), urdiv_pkg::to_field(quo_nxt)};
		end
	end

	assign out_word = res_q;

endmodule

// ----- rtl/core/urdiv_ctrl.sv -----
// ----------------------------------------------------------------------------
// urdiv_ctrl: divider controller
// Accepts a word when idle, sequences WIDTH iterations and holds the output
// valid flag; the last iteration waits while the output register is full.
// ----------------------------------------------------------------------------
module urdiv_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output urdiv_pkg::urdiv_cmd_t cmd
);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t                      state_q;
	logic [urdiv_pkg::CNT_W-1:0] cnt_q;
	logic                        m_tvalid_q;
	logic                        out_free;
	logic                        last;

	// Command decode
	always_comb begin
		out_free   = ~m_tvalid_q | m_tready;
		last       = (cnt_q == urdiv_pkg::CNT_LAST);
		s_tready   = (state_q == ST_IDLE);
		cmd.load   = s_tready & s_tvalid;
		cmd.step   = (state_q == ST_BUSY) & (~last | out_free);
		cmd.commit = (state_q == ST_BUSY) & last & out_free;
	end

	// State, iteration count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_BUSY;
						cnt_q   <= '0;
					end
				end
				ST_BUSY: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end else if (cmd.step) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

`ifndef SYNTH
	// A result is only written into a free output register
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("urdiv_ctrl: commit over a pending result");

	// Commit always comes with the final iteration
	a_commit_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (cmd.step && cnt_q == urdiv_pkg::CNT_LAST))
		else $error("urdiv_ctrl: commit outside last iteration");

	// After an accepted word no further word is taken until it completes
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (!s_tready && cnt_q == '0))
		else $error("urdiv_ctrl: ready right after load");

	// Commit makes the output valid
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("urdiv_ctrl: result lost after commit");
`endif

endmodule

// ----- rtl/core/unsigned_restoring_divider.sv -----
// ----------------------------------------------------------------------------
// unsigned_restoring_divider: unsigned integer divider, quotient and remainder
// Restoring shift-subtract divider with a stream input and a stream output.
// ----------------------------------------------------------------------------
// The operands of a word are captured on load, then the shared shift-subtract
// step gives one quotient bit per cycle, the loop that sets the rate. The
// finished word sits in an output register, so the next word is accepted while
// it waits to be taken; the last iteration stalls only while that register
// still holds an untaken result.
// A zero divisor gives an all-ones quotient and the dividend as remainder.
module unsigned_restoring_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [urdiv_pkg::WORD_W-1:0] s_tdata,  // [31:0] dividend, [63:32] divisor
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [urdiv_pkg::WORD_W-1:0] m_tdata   // [31:0] quotient, [63:32] remainder
);

	urdiv_pkg::urdiv_cmd_t cmd;

	// Sequencer
	urdiv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Arithmetic and result register
	urdiv_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.in_word  (s_tdata),
		.out_word (m_tdata)
	);

endmodule

// ----- tb/unsigned_restoring_divider_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_restoring_divider_tb: self-checking bench for the unsigned divider
// Drives dividend/divisor words with random gaps and drains quotient/remainder
// words with random stalls. Each accepted word is predicted by a bit-serial
// restoring division and compared, field by field, with the returned word.
// ----------------------------------------------------------------------------
module unsigned_restoring_divider_tb;

	localparam int FW = urdiv_pkg::FIELD_W;
	localparam int DW = urdiv_pkg::WIDTH;
	localparam int WW = urdiv_pkg::WORD_W;
	localparam int N_RANDOM = 1500;

	typedef struct {
		logic [FW-1:0] quotient;
		logic [FW-1:0] remainder;
	} div_result_t;

	// Holds the quotient/remainder pairs still owed by the block
	class quotient_board;
		div_result_t awaited[$];
		int unsigned mismatches;
		int unsigned checked;

		// Shift-subtract restoring division over DW bits, DW+1 bit partial remainder
		function div_result_t restore_divide(logic [FW-1:0] dividend, logic [FW-1:0] divisor);
			logic [DW-1:0] num;
			logic [DW-1:0] den;
			logic [DW-1:0] quo;
			logic [DW:0]   part;
			div_result_t   res;
			int            i;
			num  = DW'(dividend);
			den  = DW'(divisor);
			quo  = '0;
			part = '0;
			for (i = DW - 1; i >= 0; i--) begin
				part = {part[DW-1:0], num[i]};
				if (part >= {1'b0, den}) begin
					part   = part - {1'b0, den};
					quo[i] = 1'b1;
				end
			end
			res.quotient  = FW'(quo);
			res.remainder = FW'(part[DW-1:0]);
			return res;
		endfunction

		function void note_operands(logic [FW-1:0] dividend, logic [FW-1:0] divisor);
			awaited.push_back(restore_divide(dividend, divisor));
		endfunction

		function void check_result(logic [FW-1:0] quotient, logic [FW-1:0] remainder);
			div_result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected word: quotient %h remainder %h",
						$realtime, quotient, remainder);
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (want.quotient !== quotient || want.remainder !== remainder) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] mismatch: quotient exp %h got %h, remainder exp %h got %h",
						$realtime, want.quotient, quotient, want.remainder, remainder);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [WW-1:0] s_tdata;   // [31:0] dividend, [63:32] divisor
	logic          m_tvalid;
	logic          m_tready;
	logic [WW-1:0] m_tdata;   // [31:0] quotient, [63:32] remainder

	quotient_board sb;
	bit            tx_idle;       // sender draws gaps when set
	bit            rx_idle;       // receiver draws stalls when set
	int unsigned   sent;
	int unsigned   zero_divs;
	int unsigned   drains;

	unsigned_restoring_divider dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// Offer one word; valid stays high across back-to-back words
	task automatic send_word(input logic [FW-1:0] dividend, input logic [FW-1:0] divisor);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {divisor, dividend};
		do @(posedge clk); while (!s_tready);
		sb.note_operands(dividend, divisor);
		sent++;
		if (divisor == '0)
			zero_divs++;
		@(negedge clk);
	endtask

	// Hold off until every owed word has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		drains++;
	endtask

	// Random operands in a few shapes: full range, small divisor, big divisor,
	// zero divisor, dividend not above divisor, equal operands, random bit lengths
	task automatic pick_operands(output logic [FW-1:0] dividend, output logic [FW-1:0] divisor);
		int shape;
		shape    = $urandom_range(0, 9);
		dividend = $urandom;
		divisor  = $urandom;
		case (shape)
			0, 1, 2: ;
			3: divisor = $urandom_range(1, 255);
			4: divisor = {1'b1, (FW-1)'($urandom)};
			5: divisor = '0;
			6: if (dividend > divisor) {dividend, divisor} = {divisor, dividend};
			7: dividend = divisor;
			default: begin
				dividend = dividend >> $urandom_range(0, FW - 1);
				divisor  = divisor >> $urandom_range(0, FW - 1);
			end
		endcase
	endtask

	// Result side: random stalls, check every taken word
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata[FW-1:0], m_tdata[2*FW-1:FW]);
			@(negedge clk);
		end
	end

	// Stimulus
	initial begin
		logic [FW-1:0] dvd;
		logic [FW-1:0] dsr;
		int            k;
		int            waited;
		sb        = new();
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		sent      = 0;
		zero_divs = 0;
		drains    = 0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes, zero divisor, divisors at and above 2^31
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'h0000_0000, 32'h0000_0001);
		send_word(32'h0000_0001, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'h0000_0001);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'h0000_0000, 32'hFFFF_FFFF);
		send_word(32'h0000_0001, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'h8000_0000);
		send_word(32'h8000_0000, 32'h8000_0000);
		send_word(32'h7FFF_FFFF, 32'h8000_0000);
		send_word(32'hFFFF_FFFF, 32'h8000_0001);
		send_word(32'hC000_0000, 32'h8000_0001);
		send_word(32'h8000_0000, 32'h0000_0001);
		send_word(32'hFFFF_FFFF, 32'h0000_0003);
		send_word(32'h0000_0064, 32'h0000_0007);
		send_word(32'h0000_0007, 32'h0000_0064);
		send_word(32'h0000_0005, 32'h0000_0005);
		send_word(32'hDEAD_BEEF, 32'h0000_0010);
		send_word(32'h5555_5555, 32'hAAAA_AAAA);
		send_word(32'hAAAA_AAAA, 32'h5555_5555);

		// Random: idling patterns rotate every 100 words, two full drains
		for (k = 0; k < N_RANDOM; k++) begin
			tx_idle = ((k / 100) % 4) inside {0, 2};
			rx_idle = ((k / 100) % 4) inside {0, 1};
			if (k == 700 || k == 1100)
				drain_results();
			pick_operands(dvd, dsr);
			send_word(dvd, dsr);
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(negedge clk);
		// Let any late word show up as unexpected
		repeat (40) @(negedge clk);

		$display("Sent %0d words (%0d with zero divisor), checked %0d results, %0d drains.",
			sent, zero_divs, sb.checked, drains);
		$display("Mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/urdiv_pkg.sv
rtl/core/urdiv_dp.sv
rtl/core/urdiv_ctrl.sv
rtl/core/unsigned_restoring_divider.sv
tb/unsigned_restoring_divider_tb.sv
